[sv/itr_pkg.sv]
package itr_pkg;

    localparam int VALUE_W = 16;
    localparam int CHAR_W  = 8;

    localparam logic [VALUE_W-1:0] MAX_VALUE = 16'd3000;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic       oor;
        logic [1:0] d1000;
        logic [3:0] d100;
        logic [3:0] d10;
        logic [3:0] d1;
    } t_item;

endpackage

[sv/itr_ifs.sv]
interface itr_in_if;
    import itr_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface itr_out_if;
    import itr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface

[sv/itr_front.sv]
module itr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    itr_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output itr_pkg::t_item o_item
);
    import itr_pkg::*;

    logic               r_va;
    logic [VALUE_W-1:0] r_value;
    logic               r_vb;
    logic               r_oor_b;
    logic [1:0]         r_thou_b;
    logic [9:0]         r_rem_b;
    logic               r_vc;
    logic               r_oor_c;
    logic [1:0]         r_thou_c;
    logic [3:0]         r_hund_c;
    logic [6:0]         r_rem_c;

    logic        adv_a;
    logic        adv_b;
    logic        adv_c;
    logic        n_oor;
    logic [1:0]  n_thou;
    logic [11:0] n_thou_sub;
    logic [11:0] n_rem_a;
    logic [3:0]  n_hund;
    logic [9:0]  n_rem_b;
    logic [3:0]  n_tens;
    logic [6:0]  n_rem_c;

    assign adv_c      = !r_vc || !i_full;
    assign adv_b      = !r_vb || adv_c;
    assign adv_a      = !r_va || adv_b;
    assign i_in.ready = adv_a;
    assign o_push     = r_vc && !i_full;

    always_comb begin
        n_oor = (r_value == '0) || (r_value > MAX_VALUE);
        if (r_value >= 16'd3000) begin
            n_thou = 2'd3;
        end else if (r_value >= 16'd2000) begin
            n_thou = 2'd2;
        end else if (r_value >= 16'd1000) begin
            n_thou = 2'd1;
        end else begin
            n_thou = 2'd0;
        end
        n_thou_sub = 12'(n_thou) * 12'd1000;
        n_rem_a    = r_value[11:0] - n_thou_sub;
    end

    always_comb begin
        n_hund = '0;
        for (int k = 1; k < 10; k++) begin
            if (r_rem_b >= 10'(k * 100)) begin
                n_hund = n_hund + 4'd1;
            end
        end
        n_rem_b = r_rem_b - (10'(n_hund) * 10'd100);
    end

    always_comb begin
        n_tens = '0;
        for (int k = 1; k < 10; k++) begin
            if (r_rem_c >= 7'(k * 10)) begin
                n_tens = n_tens + 4'd1;
            end
        end
        n_rem_c = r_rem_c - (7'(n_tens) * 7'd10);
    end

    assign o_item.oor   = r_oor_c;
    assign o_item.d1000 = r_thou_c;
    assign o_item.d100  = r_hund_c;
    assign o_item.d10   = n_tens;
    assign o_item.d1    = n_rem_c[3:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (adv_a) begin
                r_va <= i_in.valid;
            end
            if (adv_b) begin
                r_vb <= r_va;
            end
            if (adv_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_value <= i_in.value;
        end
        if (adv_b) begin
            r_oor_b  <= n_oor;
            r_thou_b <= n_thou;
            r_rem_b  <= n_rem_a[9:0];
        end
        if (adv_c) begin
            r_oor_c  <= r_oor_b;
            r_thou_c <= r_thou_b;
            r_hund_c <= n_hund;
            r_rem_c  <= n_rem_b[6:0];
        end
    end

endmodule

[sv/itr_queue.sv]
module itr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  itr_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output itr_pkg::t_item o_item
);
    import itr_pkg::*;

    t_item           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[sv/itr_back.sv]
module itr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  itr_pkg::t_item i_item,
    output logic           o_pop,
    itr_out_if.source      o_out
);
    import itr_pkg::*;

    typedef enum logic [6:0] {
        ST_MSG  = 7'b0000001,
        ST_DIG  = 7'b0000010,
        ST_SEP  = 7'b0000100,
        ST_THOU = 7'b0001000,
        ST_HUND = 7'b0010000,
        ST_TENS = 7'b0100000,
        ST_ONES = 7'b1000000
    } t_seg;

    typedef enum logic [1:0] {
        SYM_ONE,
        SYM_FIVE,
        SYM_TEN
    } t_sym;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;

    function automatic logic [3:0] rom_len(input logic [3:0] d);
        logic [3:0] len;
        unique case (d)
            4'd0:    len = 4'd0;
            4'd1:    len = 4'd1;
            4'd2:    len = 4'd2;
            4'd3:    len = 4'd3;
            4'd4:    len = 4'd2;
            4'd5:    len = 4'd1;
            4'd6:    len = 4'd2;
            4'd7:    len = 4'd3;
            4'd8:    len = 4'd4;
            4'd9:    len = 4'd2;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic t_sym rom_sym(input logic [3:0] d, input logic [1:0] pos);
        t_sym sym;
        if (d == 4'd4) begin
            sym = (pos == 2'd0) ? SYM_ONE : SYM_FIVE;
        end else if (d == 4'd9) begin
            sym = (pos == 2'd0) ? SYM_ONE : SYM_TEN;
        end else if (d >= 4'd5) begin
            sym = (pos == 2'd0) ? SYM_FIVE : SYM_ONE;
        end else begin
            sym = SYM_ONE;
        end
        return sym;
    endfunction

    function automatic logic [CHAR_W-1:0] msg_char(input logic [3:0] pos);
        logic [CHAR_W-1:0] ch;
        unique case (pos)
            4'd0:    ch = "O";
            4'd1:    ch = "u";
            4'd2:    ch = "t";
            4'd3:    ch = " ";
            4'd4:    ch = "o";
            4'd5:    ch = "f";
            4'd6:    ch = " ";
            4'd7:    ch = "R";
            4'd8:    ch = "a";
            4'd9:    ch = "n";
            4'd10:   ch = "g";
            4'd11:   ch = "e";
            default: ch = " ";
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] roman_char(
        input logic [CHAR_W-1:0] one_c,
        input logic [CHAR_W-1:0] five_c,
        input logic [CHAR_W-1:0] ten_c,
        input t_sym              sym
    );
        logic [CHAR_W-1:0] ch;
        unique case (sym)
            SYM_ONE:  ch = one_c;
            SYM_FIVE: ch = five_c;
            SYM_TEN:  ch = ten_c;
            default:  ch = one_c;
        endcase
        return ch;
    endfunction

    logic              r_busy;
    t_seg              r_seg;
    logic [3:0]        r_pos;
    t_item             r_item;
    logic              r_ovalid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    logic              adv;
    logic              emit;
    logic              seg_end;
    logic              n_done;
    t_seg              n_seg;
    logic [3:0]        len;
    logic [CHAR_W-1:0] n_char;
    logic [3:0]        digit;
    logic              ne_thou;
    logic              ne_hund;
    logic              ne_tens;
    logic              ne_ones;

    assign adv     = !r_ovalid || o_out.ready;
    assign emit    = r_busy && adv;
    assign ne_thou = (r_item.d1000 != '0);
    assign ne_hund = (r_item.d100 != '0);
    assign ne_tens = (r_item.d10 != '0);
    assign ne_ones = (r_item.d1 != '0);

    always_comb begin
        unique case (r_pos[1:0])
            2'd0:    digit = {2'b00, r_item.d1000};
            2'd1:    digit = r_item.d100;
            2'd2:    digit = r_item.d10;
            2'd3:    digit = r_item.d1;
            default: digit = '0;
        endcase
    end

    always_comb begin
        n_done = 1'b0;
        n_seg  = ST_ONES;
        unique case (r_seg)
            ST_MSG: begin
                len    = 4'd12;
                n_char = msg_char(r_pos);
                n_done = 1'b1;
            end
            ST_DIG: begin
                len    = 4'd4;
                n_char = {4'd0, digit} + ASCII_ZERO;
                n_seg  = ST_SEP;
            end
            ST_SEP: begin
                len    = 4'd3;
                n_char = (r_pos == 4'd1) ? "=" : " ";
                if (ne_thou) begin
                    n_seg = ST_THOU;
                end else if (ne_hund) begin
                    n_seg = ST_HUND;
                end else if (ne_tens) begin
                    n_seg = ST_TENS;
                end else if (ne_ones) begin
                    n_seg = ST_ONES;
                end else begin
                    n_done = 1'b1;
                end
            end
            ST_THOU: begin
                len    = {2'b00, r_item.d1000};
                n_char = "M";
                if (ne_hund) begin
                    n_seg = ST_HUND;
                end else if (ne_tens) begin
                    n_seg = ST_TENS;
                end else if (ne_ones) begin
                    n_seg = ST_ONES;
                end else begin
                    n_done = 1'b1;
                end
            end
            ST_HUND: begin
                len    = rom_len(r_item.d100);
                n_char = roman_char("C", "D", "M", rom_sym(r_item.d100, r_pos[1:0]));
                if (ne_tens) begin
                    n_seg = ST_TENS;
                end else if (ne_ones) begin
                    n_seg = ST_ONES;
                end else begin
                    n_done = 1'b1;
                end
            end
            ST_TENS: begin
                len    = rom_len(r_item.d10);
                n_char = roman_char("X", "L", "C", rom_sym(r_item.d10, r_pos[1:0]));
                if (ne_ones) begin
                    n_seg = ST_ONES;
                end else begin
                    n_done = 1'b1;
                end
            end
            ST_ONES: begin
                len    = rom_len(r_item.d1);
                n_char = roman_char("I", "V", "X", rom_sym(r_item.d1, r_pos[1:0]));
                n_done = 1'b1;
            end
            default: begin
                len    = 4'd1;
                n_char = " ";
                n_done = 1'b1;
            end
        endcase
        seg_end = (r_pos == (len - 4'd1));
    end

    assign o_pop = i_valid && (!r_busy || (emit && seg_end && n_done));

    assign o_out.valid     = r_ovalid;
    assign o_out.char_code = r_char;
    assign o_out.last_char = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_seg    <= ST_MSG;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (adv) begin
                r_ovalid <= emit;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_seg  <= i_item.oor ? ST_MSG : ST_DIG;
                r_pos  <= '0;
            end else if (emit) begin
                if (seg_end) begin
                    r_pos <= '0;
                    if (n_done) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_seg <= n_seg;
                    end
                end else begin
                    r_pos <= r_pos + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (emit) begin
            r_char <= n_char;
            r_last <= seg_end && n_done;
        end
    end

endmodule

[sv/integer_to_roman_text.sv]
// Converts each 16-bit number into ASCII text, one character per output word:
// 1 to 3000 gives four zero-padded decimal digits, " = " and the Roman numeral;
// any other value gives "Out of Range". last_char marks the final word of each
// text. The character sequencer emits one word per cycle while the output is
// ready; a number's text is 8 to 21 characters long (12 when out of
// range). A three-stage digit splitter and a two-entry queue feed the
// sequencer. A number's first word passes through the three splitter stages,
// the queue, and the sequencer's item register and output register before it
// is valid. The next number is taken while earlier ones are still being
// written out.
module integer_to_roman_text (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itr_in_if.sink     i_in,
    itr_out_if.source  o_out
);
    import itr_pkg::*;

    logic  push;
    logic  full;
    logic  pop;
    logic  q_valid;
    t_item f_item;
    t_item q_item;

    itr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_item  (f_item)
    );

    itr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    itr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

[sv/itr_checker.sv]
module itr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_char_code,
    input logic       i_last_char
);

    logic [7:0] r_pend;
    logic       in_acc;
    logic       out_end;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_end = i_out_valid && i_out_ready && i_last_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (in_acc && !out_end) begin
            r_pend <= r_pend + 8'd1;
        end else if (!in_acc && out_end) begin
            r_pend <= r_pend - 8'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_char_code) && $stable(i_last_char))
        else $error("output word changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_end_needs_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_end |-> r_pend != 8'd0)
        else $error("text ended with no number outstanding");

    a_end_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last_char |->
            i_char_code == "e" || i_char_code == "I" || i_char_code == "V" ||
            i_char_code == "X" || i_char_code == "L" || i_char_code == "C" ||
            i_char_code == "D" || i_char_code == "M")
        else $error("final word is not a closing character");

endmodule

bind integer_to_roman_text itr_checker u_itr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_char_code (o_out.char_code),
    .i_last_char (o_out.last_char)
);
